// ===== hdl/rvd_pkg.sv =====
// Package for the RV32IM instruction decoder: status, format and mnemonic codes,
// opcode constants and the funct3 lookup tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rvd_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BUBBLE      = 3'd1,
    ST_BAD_OPCODE  = 3'd2,
    ST_BAD_BRANCH  = 3'd3,
    ST_BAD_LOAD    = 3'd4,
    ST_BAD_STORE   = 3'd5,
    ST_BAD_FUNCT7  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    FMT_NONE  = 4'd0,
    FMT_R     = 4'd1,
    FMT_I     = 4'd2,
    FMT_LOAD  = 4'd3,
    FMT_S     = 4'd4,
    FMT_B     = 4'd5,
    FMT_LUI   = 4'd6,
    FMT_U     = 4'd7,
    FMT_J     = 4'd8,
    FMT_SHIFT = 4'd9
  } format_t;

  typedef logic [5:0] mnemonic_t;

  localparam mnemonic_t MN_NONE   = 6'd0;
  localparam mnemonic_t MN_LUI    = 6'd1;
  localparam mnemonic_t MN_AUIPC  = 6'd2;
  localparam mnemonic_t MN_JAL    = 6'd3;
  localparam mnemonic_t MN_JALR   = 6'd4;
  localparam mnemonic_t MN_BEQ    = 6'd5;
  localparam mnemonic_t MN_BNE    = 6'd6;
  localparam mnemonic_t MN_BLT    = 6'd7;
  localparam mnemonic_t MN_BGE    = 6'd8;
  localparam mnemonic_t MN_BLTU   = 6'd9;
  localparam mnemonic_t MN_BGEU   = 6'd10;
  localparam mnemonic_t MN_LB     = 6'd11;
  localparam mnemonic_t MN_LH     = 6'd12;
  localparam mnemonic_t MN_LW     = 6'd13;
  localparam mnemonic_t MN_LBU    = 6'd14;
  localparam mnemonic_t MN_LHU    = 6'd15;
  localparam mnemonic_t MN_SB     = 6'd16;
  localparam mnemonic_t MN_SH     = 6'd17;
  localparam mnemonic_t MN_SW     = 6'd18;
  localparam mnemonic_t MN_ADDI   = 6'd19;
  localparam mnemonic_t MN_SLTI   = 6'd20;
  localparam mnemonic_t MN_SLTIU  = 6'd21;
  localparam mnemonic_t MN_XORI   = 6'd22;
  localparam mnemonic_t MN_ORI    = 6'd23;
  localparam mnemonic_t MN_ANDI   = 6'd24;
  localparam mnemonic_t MN_SLLI   = 6'd25;
  localparam mnemonic_t MN_SRAI   = 6'd26;
  localparam mnemonic_t MN_SRLI   = 6'd27;
  localparam mnemonic_t MN_ADD    = 6'd28;
  localparam mnemonic_t MN_SUB    = 6'd29;
  localparam mnemonic_t MN_MUL    = 6'd30;
  localparam mnemonic_t MN_SLL    = 6'd31;
  localparam mnemonic_t MN_MULH   = 6'd32;
  localparam mnemonic_t MN_SLT    = 6'd33;
  localparam mnemonic_t MN_MULHSU = 6'd34;
  localparam mnemonic_t MN_SLTU   = 6'd35;
  localparam mnemonic_t MN_MULHU  = 6'd36;
  localparam mnemonic_t MN_XOR    = 6'd37;
  localparam mnemonic_t MN_DIV    = 6'd38;
  localparam mnemonic_t MN_SRL    = 6'd39;
  localparam mnemonic_t MN_SRA    = 6'd40;
  localparam mnemonic_t MN_DIVU   = 6'd41;
  localparam mnemonic_t MN_OR     = 6'd42;
  localparam mnemonic_t MN_REM    = 6'd43;
  localparam mnemonic_t MN_AND    = 6'd44;
  localparam mnemonic_t MN_REMU   = 6'd45;
  localparam mnemonic_t MN_EBREAK = 6'd46;
  localparam mnemonic_t MN_ECALL  = 6'd47;
  localparam mnemonic_t MN_CSR    = 6'd48;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SR  = 3'd5;

  // funct3 -> mnemonic; MN_NONE marks an illegal funct3
  localparam mnemonic_t BRANCH_CODES [8] = '{
    MN_BEQ, MN_BNE, MN_NONE, MN_NONE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
  localparam mnemonic_t LOAD_CODES [8] = '{
    MN_LB, MN_LH, MN_LW, MN_NONE, MN_LBU, MN_LHU, MN_NONE, MN_NONE};
  localparam mnemonic_t STORE_CODES [8] = '{
    MN_SB, MN_SH, MN_SW, MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_NONE};
  localparam mnemonic_t OPIMM_CODES [8] = '{
    MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_NONE, MN_ORI, MN_ANDI};
  localparam mnemonic_t R_BASE_CODES [8] = '{
    MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND};
  localparam mnemonic_t R_ALT_CODES [8] = '{
    MN_SUB, MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_SRA, MN_NONE, MN_NONE};
  localparam mnemonic_t R_MULDIV_CODES [8] = '{
    MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV, MN_DIVU, MN_REM, MN_REMU};

endpackage

`default_nettype wire

// ===== hdl/rv32im_instruction_decoder_top.sv =====
// Top level of the RV32IM instruction decoder: input register, decode logic and
// result register. Depends on rvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// RV32IM instruction decoder.
//
// Input channel: drive instruction and raise start; the item is taken at
// the rising edge where start is high and busy is low. busy stays low, so
// an item may be offered in every cycle.
//
// Result channel: done is high for exactly one cycle with status,
// mnemonic, operand_format, register fields and immediate valid in that
// cycle. The receiver cannot stall this channel; every result must be
// captured in its strobe cycle.
//
// An item taken into the input register is decoded from it and the result
// is captured in the result register, from which it shows on the result ports.
// Throughput: one item per cycle, set by the single pass of field
// extraction and table lookup between the two registers.
//
// Reset (rst, synchronous, active high) drops any item in flight and
// holds done low; the payload registers are not cleared.
module rv32im_instruction_decoder_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [31:0]         instruction,
  output      logic                done,
  output      logic [2:0]          status,
  output      rvd_pkg::mnemonic_t  mnemonic,
  output      logic [3:0]          operand_format,
  output      logic [4:0]          dest_reg,
  output      logic [4:0]          src1_reg,
  output      logic [4:0]          src2_reg,
  output      logic signed [31:0]  immediate
);

  import rvd_pkg::*;

  // Input register stage
  logic        in_valid;
  logic [31:0] in_word;

  // Decode signals
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_shamt;
  status_t     status_next;
  mnemonic_t   mnemonic_next;
  mnemonic_t   mn_raw;
  format_t     format_next;
  logic [31:0] imm_next;
  logic [31:0] imm_raw;
  format_t     fmt_raw;

  // Never stalls: a new item may enter every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_word <= instruction;
    end
  end

  assign opc = in_word[6:0];
  assign f3  = in_word[14:12];
  assign f7  = in_word[31:25];

  assign imm_i = {{20{in_word[31]}}, in_word[31:20]};
  assign imm_s = {{20{in_word[31]}}, in_word[31:25], in_word[11:7]};
  assign imm_b = {{19{in_word[31]}}, in_word[31], in_word[7], in_word[30:25],
                  in_word[11:8], 1'b0};
  assign imm_j = {{11{in_word[31]}}, in_word[31], in_word[19:12], in_word[20],
                  in_word[30:21], 1'b0};
  assign imm_shamt = {27'd0, in_word[24:20]};

  // Single-pass decode: pick mnemonic, format and immediate by opcode,
  // then flag illegal encodings and clear mnemonic, format and immediate for them.
  always_comb begin
    status_next = ST_OK;
    mn_raw      = MN_NONE;
    fmt_raw     = FMT_NONE;
    imm_raw     = 32'd0;
    if (in_word == 32'd0) begin
      status_next = ST_BUBBLE;
    end else begin
      case (opc)
        OPC_LUI: begin
          mn_raw  = MN_LUI;
          fmt_raw = FMT_LUI;
          imm_raw = {12'd0, in_word[31:12]};
        end
        OPC_AUIPC: begin
          mn_raw  = MN_AUIPC;
          fmt_raw = FMT_U;
          imm_raw = {in_word[31:12], 12'd0};
        end
        OPC_JAL: begin
          mn_raw  = MN_JAL;
          fmt_raw = FMT_J;
          imm_raw = imm_j;
        end
        OPC_JALR: begin
          mn_raw  = MN_JALR;
          fmt_raw = FMT_LOAD;
          imm_raw = imm_i;
        end
        OPC_BRANCH: begin
          mn_raw  = BRANCH_CODES[f3];
          fmt_raw = FMT_B;
          imm_raw = imm_b;
          if (mn_raw == MN_NONE) status_next = ST_BAD_BRANCH;
        end
        OPC_LOAD: begin
          mn_raw  = LOAD_CODES[f3];
          fmt_raw = FMT_LOAD;
          imm_raw = imm_i;
          if (mn_raw == MN_NONE) status_next = ST_BAD_LOAD;
        end
        OPC_STORE: begin
          mn_raw  = STORE_CODES[f3];
          fmt_raw = FMT_S;
          imm_raw = imm_s;
          if (mn_raw == MN_NONE) status_next = ST_BAD_STORE;
        end
        OPC_OPIMM: begin
          if (f3 == F3_SR) begin
            // only bit 30 selects arithmetic vs logical right shift
            mn_raw  = in_word[30] ? MN_SRAI : MN_SRLI;
            fmt_raw = FMT_SHIFT;
            imm_raw = imm_shamt;
          end else if (f3 == F3_SLL) begin
            mn_raw  = MN_SLLI;
            fmt_raw = FMT_SHIFT;
            imm_raw = imm_shamt;
          end else begin
            mn_raw  = OPIMM_CODES[f3];
            fmt_raw = FMT_I;
            imm_raw = imm_i;
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            mn_raw = R_BASE_CODES[f3];
          end else if (f7 == F7_ALT) begin
            mn_raw = R_ALT_CODES[f3];
          end else if (f7 == F7_MULDIV) begin
            mn_raw = R_MULDIV_CODES[f3];
          end else begin
            mn_raw = MN_NONE;
          end
          fmt_raw = FMT_R;
          if (mn_raw == MN_NONE) status_next = ST_BAD_FUNCT7;
        end
        OPC_SYSTEM: begin
          if (in_word == WORD_EBREAK) begin
            mn_raw = MN_EBREAK;
          end else if (in_word == WORD_ECALL) begin
            mn_raw = MN_ECALL;
          end else begin
            mn_raw = MN_CSR;
          end
        end
        default: begin
          status_next = ST_BAD_OPCODE;
        end
      endcase
    end

    // Drop mnemonic, format and immediate on any non-ok status
    if (status_next != ST_OK) begin
      mnemonic_next = MN_NONE;
      format_next   = FMT_NONE;
      imm_next      = 32'd0;
    end else begin
      mnemonic_next = mn_raw;
      format_next   = fmt_raw;
      imm_next      = imm_raw;
    end
  end

  // Result register: strobe for one cycle per decoded item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      status         <= status_next;
      mnemonic       <= mnemonic_next;
      operand_format <= format_next;
      dest_reg       <= in_word[11:7];
      src1_reg       <= in_word[19:15];
      src2_reg       <= in_word[24:20];
      immediate      <= imm_next;
    end
  end

endmodule

`default_nettype wire
